// ===== hw/rtl/pru_pkg.sv =====
// Package for the packed raw pixel unpacker.
// Holds mode and register codes, bit-stream constants and the structs
// passed between the unpack and position modules. No dependencies.
`timescale 1ns / 1ps

package pru_pkg;

  // bit_depth_mode codes; code 3 is treated like the 16-bit mode
  localparam logic [1:0] MODE_12 = 2'd0;
  localparam logic [1:0] MODE_14 = 2'd1;
  localparam logic [1:0] MODE_16 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam int unsigned CFG_W = 15;

  localparam logic [15:0] MASK_12   = 16'h0FFF;
  localparam logic [15:0] MASK_14   = 16'h3FFF;
  localparam logic [4:0]  DEPTH_12  = 5'd12;
  localparam logic [4:0]  DEPTH_14  = 5'd14;
  localparam logic [4:0]  BYTE_BITS = 5'd8;
  // largest pending count: 13 left over plus one new byte
  localparam logic [4:0]  MAX_PEND  = 5'd21;

  typedef struct packed {
    logic        valid;
    logic [15:0] value;
  } pix_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pos_flags_t;

endpackage

// ===== hw/rtl/pru_unpack.sv =====
// Bit accumulator and pixel extraction for the raw pixel unpacker.
// Depends on pru_pkg; frame-end flags come from pru_pos.
`timescale 1ns / 1ps

module pru_unpack import pru_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [1:0]       mode_i,
  input  logic [7:0]       byte_i,
  input  pos_flags_t       flags_i,
  output pix_t             pix_o
);

  logic [23:0] acc_q, acc_d;
  logic [4:0]  pend_q, pend_d;
  logic [23:0] acc_sh;
  logic [23:0] shifted;
  logic [4:0]  pend_add;
  logic [4:0]  depth;
  logic [15:0] mask;
  logic        packed_mode;

  assign packed_mode = (mode_i == MODE_12) || (mode_i == MODE_14);
  assign depth       = (mode_i == MODE_12) ? DEPTH_12 : DEPTH_14;
  assign mask        = (mode_i == MODE_12) ? MASK_12 : MASK_14;
  assign acc_sh      = {acc_q[15:0], byte_i};
  assign pend_add    = pend_q + BYTE_BITS;

  always_comb begin
    pix_o.valid = 1'b0;
    pix_o.value = 16'd0;
    acc_d       = acc_q;
    pend_d      = pend_q;
    shifted     = 24'd0;
    if (packed_mode) begin
      acc_d  = acc_sh;
      pend_d = pend_add;
      if (pend_add >= depth) begin
        pend_d      = pend_add - depth;
        shifted     = acc_sh >> pend_d;
        pix_o.valid = 1'b1;
        pix_o.value = shifted[15:0] & mask;
      end
    end else begin
      // 16-bit little endian: low byte waits, high byte completes the pixel
      if (pend_q < BYTE_BITS) begin
        acc_d  = {16'd0, byte_i};
        pend_d = BYTE_BITS;
      end else begin
        pix_o.valid = 1'b1;
        pix_o.value = {byte_i, acc_q[7:0]};
        acc_d       = 24'd0;
        pend_d      = 5'd0;
      end
    end
    // alignment restarts after the last pixel of a frame
    if (pix_o.valid && flags_i.frame_end) begin
      acc_d  = 24'd0;
      pend_d = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 24'd0;
      pend_q <= 5'd0;
    end else if (adv_i) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MAX_PEND)
    else $error("pending bit count out of range");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && pix_o.valid && flags_i.frame_end) |=> (pend_q == 5'd0 && acc_q == 24'd0))
    else $error("accumulator not cleared after frame end");
`endif

endmodule

// ===== hw/rtl/pru_pos.sv =====
// Column and row counters for the raw pixel unpacker.
// Depends on pru_pkg; flags row end and frame end of each pixel.
`timescale 1ns / 1ps

module pru_pos import pru_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_adv_i,
  input  logic [CFG_W-1:0] width_i,
  input  logic [CFG_W-1:0] height_i,
  output pos_flags_t       flags_o
);

  localparam int unsigned CW = $clog2(MAX_DIMENSION);
  localparam int unsigned EW = 17;
  localparam logic [EW-1:0] MAX_V  = EW'(MAX_DIMENSION);
  localparam logic [CW-1:0] LAST_V = CW'(MAX_DIMENSION - 1);

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic [CW-1:0] last_w, last_h;
  logic [EW-1:0] w_ext, h_ext;
  logic [EW-1:0] w_m1, h_m1;

  assign w_ext = EW'(width_i);
  assign h_ext = EW'(height_i);
  assign w_m1  = w_ext - EW'(1);
  assign h_m1  = h_ext - EW'(1);

  // clamp sizes to 1..MAX_DIMENSION, expressed as last index
  always_comb begin
    if (w_ext == '0)         last_w = '0;
    else if (w_ext > MAX_V)  last_w = LAST_V;
    else                     last_w = w_m1[CW-1:0];
    if (h_ext == '0)         last_h = '0;
    else if (h_ext > MAX_V)  last_h = LAST_V;
    else                     last_h = h_m1[CW-1:0];
  end

  always_comb begin
    flags_o.row_end   = (col_q >= last_w);
    flags_o.frame_end = flags_o.row_end && (row_q >= last_h);
    col_d = col_q + CW'(1);
    row_d = row_q;
    if (flags_o.row_end) begin
      col_d = '0;
      row_d = flags_o.frame_end ? '0 : row_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_adv_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

`ifndef SYNTHESIS
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_adv_i && flags_o.row_end) |=> (col_q == '0))
    else $error("column counter did not wrap at row end");
`endif

endmodule

// ===== hw/rtl/packed_raw_pixel_unpacker.sv =====
// An accepted byte is held in the input register, then its pixel in the result register.
// Throughput: one byte per cycle while the result register is free or draining; a pixel per
// 1.5 bytes (12-bit), 1.75 bytes (14-bit) or 2 bytes (16-bit).
// Reset (rst_ni low, asynchronous): pipeline empty, accumulator and counters zero,
// mode 12-bit, width 1, height 1.
// Top level: stream ports, config and pipeline registers; uses pru_pkg, pru_unpack, pru_pos.
`timescale 1ns / 1ps

module packed_raw_pixel_unpacker import pru_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] data_byte
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [15:0] pixel_value
  output logic             m_axis_tlast_o,   // row_end
  output logic             m_axis_tuser_o    // frame_end
);

  logic [1:0]       mode_q;
  logic [CFG_W-1:0] width_q, height_q;

  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       out_v_q, out_v_d;
  logic [15:0] out_pix_q;
  logic       out_row_q, out_frame_q;

  logic       adv;
  logic       s_acc;
  pix_t       pix;
  pos_flags_t flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_12;
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_wdata_i[1:0];
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // the held byte moves on when the result register is free or draining
  assign adv             = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign in_v_d  = s_acc || (in_v_q && !adv);
  assign out_v_d = adv ? pix.valid : (out_v_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) in_byte_q <= s_axis_tdata_i;
    if (adv && pix.valid) begin
      out_pix_q   <= pix.value;
      out_row_q   <= flags.row_end;
      out_frame_q <= flags.frame_end;
    end
  end

  pru_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .mode_i  (mode_q),
    .byte_i  (in_byte_q),
    .flags_i (flags),
    .pix_o   (pix)
  );

  pru_pos #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_adv_i (adv && pix.valid),
    .width_i   (width_q),
    .height_i  (height_q),
    .flags_o   (flags)
  );

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tlast_o  = out_row_q;
  assign m_axis_tuser_o  = out_frame_q;

`ifndef SYNTHESIS
  a_frame_is_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("frame end without row end");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_v_q && out_v_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");
`endif

endmodule
